// ===== hdl/lfw_pkg.sv =====
// ----------------------------------------------------------------------------
// lfw_pkg
// Shared constants and controller/datapath interface types of the line fold
// block.
// ----------------------------------------------------------------------------
package lfw_pkg;

  // Default sizes of the block.
  localparam int unsigned DefMaxWidth = 63;
  localparam int unsigned DefMaxLine  = 4095;

  // Configuration port geometry and register indexes.
  localparam int unsigned CfgW    = 6;
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CfgFoldWidth    = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgBreakAtBlank = CfgIdxW'(1);
  localparam logic [CfgW-1:0]    FoldWidthRst    = CfgW'(63);

  // Character codes.
  localparam logic [7:0] CharNewline = 8'd10;
  localparam logic [7:0] CharBlank   = 8'd32;
  localparam logic [7:0] CharEnd     = 8'd0;

  // Request kinds.
  localparam logic KindFlush = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch;         // capture the incoming byte
    logic take;          // write the held byte into the ring
    logic flush_start;   // set up emission of the whole buffer
    logic scan_start;    // start the blank search at the width boundary
    logic scan_dec;      // step the blank search one position back
    logic piece_start;   // set up emission of one piece
    logic piece_blank;   // the piece ends at the blank found by the search
    logic emit_byte;     // load the output register from the ring
    logic emit_nl;       // load the output register with a newline
    logic finish_flush;  // empty the buffer and restart the line
    logic finish_piece;  // drop the emitted piece from the buffer
  } lfw_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_end;
    logic is_nl;
    logic len_zero;
    logic len_max;
    logic fill_zero;
    logic over_width;
    logic blank_mode;
    logic width_one;
    logic ram_blank;
    logic idx_one;
    logic emit_last;
    logic out_free;
  } lfw_stat_t;

endpackage

// ===== hdl/line_fold_wrapper_core.sv =====
// ----------------------------------------------------------------------------
// line_fold_wrapper_core
// Folds a text byte stream so that no emitted line exceeds the set width,
// breaking hard or at the last blank.
//
// Channel  Direction  Handshake              Payload
// in       input      in_valid_i/in_stall_o  kind_i, char_in_i
// out      output     out_valid_o/out_stall_i char_out_o, last_of_run_o
// cfg      input      cfg_we_i               cfg_index_i, cfg_data_i
//
// A byte that causes no break is accepted, then written into the ring.
// A break adds, in blank mode, a search over up to width-1 positions (a
// ring read and a compare each), then a ring read and an output load per
// emitted byte and the newline; a line end takes the accept, a read and a
// load per buffered byte and the newline, and a line cut adds the ring
// write after it. The byte ring is one RAM with a registered read port,
// hence the read step. Reset needs no clearing pass; out_stall_i only holds
// emission, the remaining bytes wait in the ring and the input stays stalled.
// ----------------------------------------------------------------------------
module line_fold_wrapper_core
  import lfw_pkg::*;
#(
  parameter int unsigned MAX_WIDTH = DefMaxWidth,
  parameter int unsigned MAX_LINE  = DefMaxLine
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               kind_i,
  input  logic [7:0]         char_in_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [7:0]         char_out_o,
  output logic               last_of_run_o,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CfgW-1:0]    cfg_data_i
);

  lfw_cmd_t  cmd;
  lfw_stat_t stat;

  // Sequencer.
  lfw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Ring, counters and output register.
  lfw_datapath #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_LINE  (MAX_LINE)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .kind_i        (kind_i),
    .char_in_i     (char_in_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .char_out_o    (char_out_o),
    .last_of_run_o (last_of_run_o)
  );

endmodule

// ===== hdl/lfw_ram.sv =====
// ----------------------------------------------------------------------------
// lfw_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module lfw_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write and registered read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/lfw_datapath.sv =====
// ----------------------------------------------------------------------------
// lfw_datapath
// Byte ring, line counters, configuration registers and output register of
// the line fold block.
// ----------------------------------------------------------------------------
module lfw_datapath
  import lfw_pkg::*;
#(
  parameter int unsigned MAX_WIDTH = DefMaxWidth,
  parameter int unsigned MAX_LINE  = DefMaxLine
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               kind_i,
  input  logic [7:0]         char_in_i,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CfgW-1:0]    cfg_data_i,
  input  lfw_cmd_t           cmd_i,
  output lfw_stat_t          stat_o,
  input  logic               out_stall_i,
  output logic               out_valid_o,
  output logic [7:0]         char_out_o,
  output logic               last_of_run_o
);

  localparam int unsigned Depth = 2 ** $clog2(MAX_WIDTH + 1);
  localparam int unsigned AddrW = $clog2(Depth);
  localparam int unsigned FillW = AddrW + 1;
  localparam int unsigned LenW  = $clog2(MAX_LINE + 1);

  logic [CfgW-1:0]  fold_width_q;
  logic             blank_q;
  logic [AddrW-1:0] head_q;
  logic [FillW-1:0] fill_q;
  logic [LenW-1:0]  len_q;
  logic [7:0]       byte_q;
  logic [AddrW-1:0] idx_q;
  logic [AddrW-1:0] cnt_q;
  logic [AddrW-1:0] drop_q;
  logic [7:0]       out_char_q;
  logic             out_last_q;
  logic             out_valid_q;

  logic [AddrW-1:0] width_eff;
  logic [AddrW-1:0] waddr;
  logic [AddrW-1:0] raddr;
  logic [7:0]       ram_rdata;
  logic [FillW:0]   fill_inc;
  logic             out_free;

  // Effective width: zero acts as one, values above the maximum are capped.
  always_comb begin
    if (fold_width_q == '0) begin
      width_eff = AddrW'(1);
    end else if (fold_width_q > CfgW'(MAX_WIDTH)) begin
      width_eff = AddrW'(MAX_WIDTH);
    end else begin
      width_eff = AddrW'(fold_width_q);
    end
  end

  // Ring addressing: writes append at the tail, reads go relative to the head.
  assign waddr = head_q + fill_q[AddrW-1:0];
  assign raddr = head_q + idx_q;

  lfw_ram #(
    .Width (8),
    .Depth (Depth)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (cmd_i.take),
    .waddr_i (waddr),
    .wdata_i (byte_q),
    .raddr_i (raddr),
    .rdata_o (ram_rdata)
  );

  assign fill_inc = {1'b0, fill_q} + (FillW + 1)'(1);
  assign out_free = !out_valid_q || !out_stall_i;

  // Status toward the controller.
  always_comb begin
    stat_o.is_end     = (kind_i == KindFlush) || (char_in_i == CharEnd);
    stat_o.is_nl      = (char_in_i == CharNewline);
    stat_o.len_zero   = (len_q == '0);
    stat_o.len_max    = (len_q >= LenW'(MAX_LINE));
    stat_o.fill_zero  = (fill_q == '0);
    stat_o.over_width = (fill_inc > (FillW + 1)'(width_eff));
    stat_o.blank_mode = blank_q;
    stat_o.width_one  = (width_eff == AddrW'(1));
    stat_o.ram_blank  = (ram_rdata == CharBlank);
    stat_o.idx_one    = (idx_q == AddrW'(1));
    stat_o.emit_last  = ((AddrW + 1)'(idx_q) + (AddrW + 1)'(1)) == (AddrW + 1)'(cnt_q);
    stat_o.out_free   = out_free;
  end

  // Configuration registers, ring pointers, line length and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fold_width_q <= FoldWidthRst;
      blank_q      <= 1'b0;
      head_q       <= '0;
      fill_q       <= '0;
      len_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i && (cfg_index_i == CfgFoldWidth)) begin
        fold_width_q <= cfg_data_i;
      end
      if (cfg_we_i && (cfg_index_i == CfgBreakAtBlank)) begin
        blank_q <= cfg_data_i[0];
      end
      priority if (cmd_i.take) begin
        fill_q <= fill_inc[FillW-1:0];
        len_q  <= len_q + LenW'(1);
      end else if (cmd_i.finish_flush) begin
        head_q <= '0;
        fill_q <= '0;
        len_q  <= '0;
      end else if (cmd_i.finish_piece) begin
        head_q <= head_q + drop_q;
        fill_q <= fill_q - FillW'(drop_q);
      end else begin
        fill_q <= fill_q;
      end
      if (cmd_i.emit_byte || cmd_i.emit_nl) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Held byte, emit and scan indexes, piece sizes and output payload.
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      byte_q <= char_in_i;
    end
    if (cmd_i.flush_start) begin
      cnt_q <= fill_q[AddrW-1:0];
      idx_q <= '0;
    end
    if (cmd_i.scan_start) begin
      idx_q <= width_eff - AddrW'(1);
    end
    if (cmd_i.scan_dec) begin
      idx_q <= idx_q - AddrW'(1);
    end
    if (cmd_i.piece_start) begin
      idx_q <= '0;
      if (cmd_i.piece_blank) begin
        cnt_q  <= idx_q;
        drop_q <= idx_q + AddrW'(1);
      end else begin
        cnt_q  <= width_eff;
        drop_q <= width_eff;
      end
    end
    if (cmd_i.emit_byte) begin
      idx_q      <= idx_q + AddrW'(1);
      out_char_q <= ram_rdata;
      out_last_q <= 1'b0;
    end
    if (cmd_i.emit_nl) begin
      out_char_q <= CharNewline;
      out_last_q <= 1'b1;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign char_out_o    = out_char_q;
  assign last_of_run_o = out_last_q;

`ifndef SYNTHESIS
  // The buffer never holds more than one byte past the widest piece.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FillW'(MAX_WIDTH + 1))
    else $error("line fold buffer overfilled");

  // An empty line has an empty buffer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (len_q == '0) |-> (fill_q == '0))
    else $error("bytes buffered on an empty line");

  // The output register is only loaded when its content is gone or leaving.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit_byte || cmd_i.emit_nl) |-> (!out_valid_q || !out_stall_i))
    else $error("output register overwritten");

  // Every run ends with a newline, and only newlines end a run.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_last_q == (out_char_q == CharNewline)))
    else $error("run end marker out of place");
`endif

endmodule

// ===== hdl/lfw_ctrl.sv =====
// ----------------------------------------------------------------------------
// lfw_ctrl
// Sequencer of the line fold block: takes requests, runs the blank search
// and steps the emission of pieces and whole lines.
// ----------------------------------------------------------------------------
module lfw_ctrl
  import lfw_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  lfw_stat_t stat_i,
  output lfw_cmd_t  cmd_o
);

  typedef enum logic [6:0] {
    StIdle    = 7'b0000001,
    StTake    = 7'b0000010,
    StScanRd  = 7'b0000100,
    StScanChk = 7'b0001000,
    StEmitRd  = 7'b0010000,
    StEmitWr  = 7'b0100000,
    StNewline = 7'b1000000
  } lfw_state_e;

  lfw_state_e state_q, state_d;
  logic       piece_q, piece_d;
  logic       take_pend_q, take_pend_d;

  assign in_stall_o = (state_q != StIdle);

  // Next state and command decode.
  always_comb begin
    state_d     = state_q;
    piece_d     = piece_q;
    take_pend_d = take_pend_q;
    cmd_o       = '0;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          priority if (stat_i.is_end) begin
            if (!stat_i.len_zero) begin
              cmd_o.flush_start = 1'b1;
              piece_d           = 1'b0;
              take_pend_d       = 1'b0;
              state_d           = stat_i.fill_zero ? StNewline : StEmitRd;
            end
          end else if (stat_i.is_nl) begin
            cmd_o.flush_start = 1'b1;
            piece_d           = 1'b0;
            take_pend_d       = 1'b0;
            state_d           = stat_i.fill_zero ? StNewline : StEmitRd;
          end else begin
            cmd_o.latch = 1'b1;
            if (stat_i.len_max) begin
              // Line cut: end the current line, then take the byte.
              cmd_o.flush_start = 1'b1;
              piece_d           = 1'b0;
              take_pend_d       = 1'b1;
              state_d           = stat_i.fill_zero ? StNewline : StEmitRd;
            end else begin
              state_d = StTake;
            end
          end
        end
      end
      StTake: begin
        cmd_o.take  = 1'b1;
        take_pend_d = 1'b0;
        if (stat_i.over_width) begin
          piece_d = 1'b1;
          if (stat_i.blank_mode && !stat_i.width_one) begin
            cmd_o.scan_start = 1'b1;
            state_d          = StScanRd;
          end else begin
            cmd_o.piece_start = 1'b1;
            state_d           = StEmitRd;
          end
        end else begin
          state_d = StIdle;
        end
      end
      StScanRd: begin
        state_d = StScanChk;
      end
      StScanChk: begin
        if (stat_i.ram_blank) begin
          cmd_o.piece_start = 1'b1;
          cmd_o.piece_blank = 1'b1;
          state_d           = StEmitRd;
        end else if (stat_i.idx_one) begin
          cmd_o.piece_start = 1'b1;
          state_d           = StEmitRd;
        end else begin
          cmd_o.scan_dec = 1'b1;
          state_d        = StScanRd;
        end
      end
      StEmitRd: begin
        state_d = StEmitWr;
      end
      StEmitWr: begin
        if (stat_i.out_free) begin
          cmd_o.emit_byte = 1'b1;
          state_d         = stat_i.emit_last ? StNewline : StEmitRd;
        end
      end
      StNewline: begin
        if (stat_i.out_free) begin
          cmd_o.emit_nl = 1'b1;
          if (piece_q) begin
            cmd_o.finish_piece = 1'b1;
            state_d            = StIdle;
          end else begin
            cmd_o.finish_flush = 1'b1;
            state_d            = take_pend_q ? StTake : StIdle;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      piece_q     <= 1'b0;
      take_pend_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      piece_q     <= piece_d;
      take_pend_q <= take_pend_d;
    end
  end

endmodule

// ===== tb/tb_line_fold_wrapper_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_line_fold_wrapper_core
// Self-checking bench for the line fold block. Requests are driven through the
// valid/stall input channel and every emitted byte is checked against a
// predictor of the fold. The run covers short directed cases, an output
// back-pressure burst and random text under several register settings and
// idle patterns.
// ----------------------------------------------------------------------------
module tb_line_fold_wrapper_core;
  import lfw_pkg::*;

  localparam logic                KindText      = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgIdxSpareLo = CfgIdxW'(2);
  localparam logic [CfgIdxW-1:0] CfgIdxSpareHi = CfgIdxW'(3);
  localparam int unsigned         SettleCycles  = 160;
  localparam int unsigned         HoldCycles    = 400;
  localparam int unsigned         WatchdogLimit = 5000;
  localparam int unsigned         HalfItems     = 40;

  // One emitted byte as the output channel shows it.
  typedef struct {
    logic [7:0] ch;
    logic       last;
  } fold_out_t;

  // Predicts the folded output of each request and checks the block against it.
  class fold_scoreboard;
    logic [7:0]  held [64];
    logic [5:0]  held_head;
    logic [6:0]  held_count;
    int unsigned line_len;
    logic [5:0]  width_reg;
    bit          blank_mode;
    fold_out_t   expected_q [$];
    int unsigned step_count;
    int unsigned errors;
    int unsigned checked;
    int unsigned requests;

    function new();
      held_head  = '0;
      held_count = '0;
      line_len   = 0;
      width_reg  = FoldWidthRst;
      blank_mode = 1'b0;
      errors     = 0;
      checked    = 0;
      requests   = 0;
    endfunction

    function void set_register(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] data);
      case (idx)
        CfgFoldWidth:    width_reg = data;
        CfgBreakAtBlank: blank_mode = data[0];
        default: ;
      endcase
    endfunction

    // A width of zero behaves as one.
    function int unsigned fold_limit();
      return (width_reg == 0) ? 1 : int'(width_reg);
    endfunction

    // At most 64 bytes are emitted for a single request.
    function void push_char(logic [7:0] c);
      fold_out_t item;
      if (step_count < 64) begin
        item.ch   = c;
        item.last = 1'b0;
        expected_q.push_back(item);
        step_count++;
      end
    endfunction

    function logic [7:0] held_at(int unsigned i);
      return held[6'(held_head + i)];
    endfunction

    function void discard(int unsigned d);
      if (d > held_count) d = held_count;
      held_head  = 6'(held_head + d);
      held_count = 7'(held_count - d);
    endfunction

    // Line end: everything buffered goes out as one piece.
    function void end_line();
      int unsigned i;
      for (i = 0; i < held_count; i++) push_char(held_at(i));
      push_char(CharNewline);
      held_head  = '0;
      held_count = '0;
      line_len   = 0;
    endfunction

    // Break decision once the byte past the width boundary is buffered.
    function void cut_piece();
      int unsigned w;
      int unsigned cut;
      int unsigned k;
      w   = fold_limit();
      cut = 0;
      if (blank_mode) begin
        for (k = 1; k < w; k++) if (held_at(k) == CharBlank) cut = k;
      end
      if (cut > 0) begin
        for (k = 0; k < cut; k++) push_char(held_at(k));
        push_char(CharNewline);
        discard(cut + 1);
      end else begin
        for (k = 0; k < w; k++) push_char(held_at(k));
        push_char(CharNewline);
        discard(w);
      end
    endfunction

    function void note_request(logic kind, logic [7:0] c);
      int unsigned first;
      first      = expected_q.size();
      step_count = 0;
      requests++;
      if (kind == KindFlush || c == CharEnd) begin
        if (line_len > 0) end_line();
      end else if (c == CharNewline) begin
        end_line();
      end else begin
        // A full length line is closed before the new byte starts the next one.
        if (line_len >= DefMaxLine) end_line();
        if (held_count < 64) begin
          held[6'(held_head + held_count)] = c;
          held_count++;
        end
        line_len++;
        if (held_count > fold_limit()) cut_piece();
      end
      if (expected_q.size() > first) expected_q[expected_q.size() - 1].last = 1'b1;
    endfunction

    function void check_result(logic [7:0] c, logic last);
      fold_out_t want;
      checked++;
      if (expected_q.size() == 0) begin
        if (errors < 10)
          $display("ERROR: unexpected result char_out=%02h last_of_run=%0b", c, last);
        errors++;
      end else begin
        want = expected_q.pop_front();
        if (want.ch !== c || want.last !== last) begin
          if (errors < 10)
            $display("ERROR: result %0d: expected char_out=%02h last_of_run=%0b, %s%02h %s%0b",
                     checked, want.ch, want.last, "got char_out=", c, "last_of_run=", last);
          errors++;
        end
      end
    endfunction
  endclass

  logic               clk_i         = 1'b0;
  logic               rst_ni        = 1'b0;
  logic               in_valid_i    = 1'b0;
  logic               in_stall_o;
  logic               kind_i        = KindText;
  logic [7:0]         char_in_i     = 8'h00;
  logic               out_valid_o;
  logic               out_stall_i   = 1'b0;
  logic [7:0]         char_out_o;
  logic               last_of_run_o;
  logic               cfg_we_i      = 1'b0;
  logic [CfgIdxW-1:0] cfg_index_i   = CfgFoldWidth;
  logic [CfgW-1:0]    cfg_data_i    = '0;

  fold_scoreboard sb = new();
  int unsigned    send_idle_pct = 22;
  int unsigned    recv_idle_pct = 71;
  bit             hold_go = 1'b0;
  int unsigned    hold_left = 0;
  int unsigned    settings_written = 0;

  line_fold_wrapper_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .kind_i        (kind_i),
    .char_in_i     (char_in_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .char_out_o    (char_out_o),
    .last_of_run_o (last_of_run_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #2 clk_i = ~clk_i;

  // Receiver: random stalls, or a long hold-off when the sequence asks for one.
  always @(negedge clk_i) begin
    if (hold_go) begin
      hold_left = HoldCycles;
      hold_go   = 1'b0;
    end
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Every accepted result is checked at the clock edge that takes it.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(char_out_o, last_of_run_o);
  end

  // Watchdog: ends the run after a long stretch without any handshake.
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < WatchdogLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet = 0;
      else quiet++;
    end
    $display("Watchdog: no handshake for %0d cycles", WatchdogLimit);
    $display("line_fold_wrapper_core verification failed");
    $finish;
  end

  // Offers one request, holding it until the block takes it.
  task automatic offer_request(input logic k, input logic [7:0] c);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i     <= k;
    char_in_i  <= c;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_request(k, c);
    @(negedge clk_i);
  endtask

  task automatic offer_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) offer_request(KindText, s[i]);
  endtask

  // Stops offering, waits for every expected byte, then lets the block settle.
  task automatic drain_block();
    in_valid_i <= 1'b0;
    while (sb.expected_q.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  // Register writes happen only while the block is idle.
  task automatic write_register(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_register(idx, data);
    settings_written++;
    @(negedge clk_i);
  endtask

  // Random text: lines of words around the fold width, with some noise bytes.
  task automatic offer_random_lines(input int unsigned n_items);
    int unsigned sent;
    int unsigned target;
    int unsigned pos;
    int unsigned r;
    logic        k;
    logic [7:0]  c;
    bit          counted;
    sent   = 0;
    pos    = 0;
    target = $urandom_range(0, 2 * sb.fold_limit() + 6);
    while (sent < n_items) begin
      r = $urandom_range(99);
      if (pos >= target) begin
        k = KindText;
        c = CharNewline;
        if (r >= 85) begin
          c = CharEnd;
        end else if (r >= 70) begin
          k = KindFlush;
          c = 8'($urandom_range(255));
        end
        pos    = 0;
        target = $urandom_range(0, 2 * sb.fold_limit() + 6);
      end else begin
        k = KindText;
        if (r < 5) c = 8'($urandom_range(255));
        else if (r < 25) c = CharBlank;
        else c = 8'($urandom_range(126, 33));
        pos++;
      end
      // A flush of an empty line does nothing and is not counted.
      counted = !((k == KindFlush || c == CharEnd) && sb.line_len == 0);
      offer_request(k, c);
      if (counted) sent++;
    end
  endtask

  // Main sequence.
  initial begin
    int unsigned     phase;
    int unsigned     half;
    int unsigned     i;
    int unsigned     wv;
    bit              bv;
    logic [CfgW-1:0] data;

    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Flush and newline on an empty line, byte extremes ended by a zero byte.
    offer_request(KindFlush, 8'hA5);
    offer_request(KindText, CharNewline);
    offer_request(KindText, 8'h01);
    offer_request(KindText, 8'hFF);
    offer_request(KindText, 8'h80);
    offer_request(KindText, 8'h7F);
    offer_request(KindText, CharEnd);
    drain_block();

    // Width zero acts as one; the spare register indexes are ignored.
    write_register(CfgFoldWidth, '0);
    write_register(CfgBreakAtBlank, 6'h3F);
    write_register(CfgIdxSpareLo, 6'h05);
    write_register(CfgIdxSpareHi, 6'h2A);
    offer_text("a b\n");
    drain_block();
    write_register(CfgFoldWidth, 6'd5);
    offer_text("ab cd ef\n");

    // Width and mode changes in the middle of a line, closed by a flush.
    offer_text("abcdefg");
    drain_block();
    write_register(CfgFoldWidth, 6'd3);
    offer_text("h");
    drain_block();
    write_register(CfgBreakAtBlank, 6'h00);
    offer_text("i j");
    offer_request(KindFlush, 8'hFF);
    drain_block();

    // Output held off while the sender keeps going, so the input stalls.
    write_register(CfgFoldWidth, 6'd1);
    hold_go = 1'b1;
    for (i = 0; i < 48; i++) offer_request(KindText, 8'($urandom_range(126, 33)));
    offer_request(KindText, CharNewline);
    drain_block();

    // Random text under three idle patterns and six register settings.
    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 22;
          recv_idle_pct = 71;
        end
        1: begin
          send_idle_pct = 71;
          recv_idle_pct = 22;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (half = 0; half < 2; half++) begin
        case (phase * 2 + half)
          0: begin
            wv = 1;
            bv = 1'b1;
          end
          1: begin
            wv = 63;
            bv = 1'b0;
          end
          2: begin
            wv = $urandom_range(2, 10);
            bv = 1'b1;
          end
          3: begin
            wv = 0;
            bv = 1'b0;
          end
          4: begin
            wv = $urandom_range(1, 63);
            bv = $urandom_range(1);
          end
          default: begin
            wv = $urandom_range(3, 20);
            bv = 1'b1;
          end
        endcase
        data    = CfgW'($urandom_range(63));
        data[0] = bv;
        write_register(CfgFoldWidth, CfgW'(wv));
        write_register(CfgBreakAtBlank, data);
        offer_random_lines(HalfItems);
        drain_block();
      end
    end

    $display("Run covered %0d requests and %0d result bytes over %0d register writes,",
             sb.requests, sb.checked, settings_written);
    $display("with directed cases, an output hold-off and random text in three idle patterns.");
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("line_fold_wrapper_core verification clean");
    end else begin
      $display("%0d mismatches, %0d results still expected", sb.errors, sb.expected_q.size());
      $display("line_fold_wrapper_core verification failed");
    end
    $finish;
  end

endmodule

// ===== line_fold_wrapper_core.f =====
hdl/lfw_pkg.sv
hdl/lfw_ram.sv
hdl/lfw_datapath.sv
hdl/lfw_ctrl.sv
hdl/line_fold_wrapper_core.sv
tb/tb_line_fold_wrapper_core.sv
